### rtl/core/owrs_pkg.sv
package owrs_pkg;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int KIND_W      = 2;
    localparam int FAMILY_W    = 8;
    localparam int CMD_W       = 8;
    localparam int S_TDATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PRELOAD_PATH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FAMILY_CODE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FAMILY_FILTER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_ONLY    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SEARCH_CMD    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_CMD     = 3'd5;

    localparam logic [CMD_W-1:0] SEARCH_CMD_RST = 8'hF0;
    localparam logic [CMD_W-1:0] ALARM_CMD_RST  = 8'hEC;

    localparam logic [KIND_W-1:0] KIND_START = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESET = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BIT   = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_RESET = 3'b010,
        PH_BITS  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              first_bit;
        logic              complement_bit;
    } item_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] preload_path;
        logic [FAMILY_W-1:0]   family_code;
        logic                  family_filter_on;
        logic                  alarm_only;
        logic [CMD_W-1:0]      search_command;
        logic [CMD_W-1:0]      alarm_command;
    } cfg_t;

endpackage

### rtl/core/owrs_cfg_regs.sv
module owrs_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [owrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owrs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output owrs_pkg::cfg_t                   cfg
);
    import owrs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_PRELOAD_PATH:  cfg_next.preload_path     = cfg_data;
                REG_FAMILY_CODE:   cfg_next.family_code      = cfg_data[FAMILY_W-1:0];
                REG_FAMILY_FILTER: cfg_next.family_filter_on = cfg_data[0];
                REG_ALARM_ONLY:    cfg_next.alarm_only       = cfg_data[0];
                REG_SEARCH_CMD:    cfg_next.search_command   = cfg_data[CMD_W-1:0];
                REG_ALARM_CMD:     cfg_next.alarm_command    = cfg_data[CMD_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preload_path     <= '0;
            cfg_reg.family_code      <= '0;
            cfg_reg.family_filter_on <= 1'b0;
            cfg_reg.alarm_only       <= 1'b0;
            cfg_reg.search_command   <= SEARCH_CMD_RST;
            cfg_reg.alarm_command    <= ALARM_CMD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/owrs_in_stage.sv
module owrs_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  owrs_pkg::item_t s_item,
    output logic            item_valid,
    output owrs_pkg::item_t item,
    input  logic            advance
);
    import owrs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule

### rtl/core/owrs_engine.sv
module owrs_engine #(
    parameter int ID_BITS = 64
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  owrs_pkg::cfg_t             cfg,
    input  logic                       item_valid,
    input  owrs_pkg::item_t            item,
    output logic                       advance,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       write_bit,
    output logic [owrs_pkg::CMD_W-1:0] command_code,
    output logic [ID_BITS-1:0]         rom_id,
    output logic                       id_valid,
    output logic                       search_done,
    output logic                       no_device,
    output logic                       family_mismatch
);
    import owrs_pkg::*;

    localparam int SLOT_W = $clog2(ID_BITS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(ID_BITS - 1);

    // search state
    phase_t              phase_reg, phase_next;
    logic [ID_BITS-1:0]  path_reg, path_next;
    logic [ID_BITS-1:0]  found_reg, found_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                lz_valid_reg, lz_valid_next;   // a 0-taken discrepancy seen
    logic [SLOT_W-1:0]   lz_idx_reg, lz_idx_next;       // most recent one

    // result register
    logic                out_valid_reg;
    logic                wbit_reg, wbit_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [ID_BITS-1:0]  rom_reg, rom_next;
    logic                idv_reg, idv_next;
    logic                done_reg, done_next;
    logic                nodev_reg, nodev_next;
    logic                mism_reg, mism_next;

    logic [ID_BITS-1:0]  preload_path;
    logic [ID_BITS-1:0]  found_bit;
    logic [ID_BITS-1:0]  branch_path;
    logic                path_bit;
    logic                dir;

    assign advance = item_valid && (!out_valid_reg || m_ready);

    assign preload_path = cfg.preload_path[ID_BITS-1:0];
    assign path_bit     = path_reg[slot_reg];
    assign dir          = (item.first_bit == item.complement_bit) ? path_bit : item.first_bit;

    always_comb begin
        found_bit           = found_reg;
        found_bit[slot_reg] = dir;
    end

    // next path: found bits below the discrepancy, discrepancy bit set, rest clear
    always_comb begin
        for (int i = 0; i < ID_BITS; i++) begin
            if (SLOT_W'(i) < lz_idx_next) begin
                branch_path[i] = found_bit[i];
            end else begin
                branch_path[i] = (SLOT_W'(i) == lz_idx_next);
            end
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        path_next     = path_reg;
        found_next    = found_reg;
        slot_next     = slot_reg;
        lz_valid_next = lz_valid_reg;
        lz_idx_next   = lz_idx_reg;
        wbit_next     = 1'b0;
        cmd_next      = '0;
        rom_next      = '0;
        idv_next      = 1'b0;
        done_next     = 1'b0;
        nodev_next    = 1'b0;
        mism_next     = 1'b0;

        case (item.kind)
            KIND_START: begin
                path_next = preload_path;
                if (cfg.family_filter_on) begin
                    path_next[FAMILY_W-1:0] = cfg.family_code;
                end
                found_next    = '0;
                slot_next     = '0;
                lz_valid_next = 1'b0;
                phase_next    = PH_RESET;
            end
            KIND_RESET: begin
                if (phase_reg == PH_RESET || phase_reg == PH_BITS) begin
                    if (item.first_bit) begin
                        cmd_next      = cfg.alarm_only ? cfg.alarm_command
                                                       : cfg.search_command;
                        found_next    = '0;
                        slot_next     = '0;
                        lz_valid_next = 1'b0;
                        phase_next    = PH_BITS;
                    end else begin
                        nodev_next = 1'b1;
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            KIND_BIT: begin
                if (phase_reg == PH_BITS) begin
                    if (item.first_bit && item.complement_bit) begin
                        wbit_next  = 1'b1;
                        nodev_next = 1'b1;
                        done_next  = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        wbit_next  = dir;
                        found_next = found_bit;
                        if (!item.first_bit && !item.complement_bit && !dir) begin
                            lz_valid_next = 1'b1;
                            lz_idx_next   = slot_reg;
                        end
                        slot_next = slot_reg + SLOT_W'(1);
                        if (slot_reg == SLOT_LAST) begin
                            slot_next = '0;
                            rom_next  = found_bit;
                            if (cfg.family_filter_on &&
                                found_bit[FAMILY_W-1:0] != cfg.family_code) begin
                                mism_next  = 1'b1;
                                done_next  = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                idv_next = 1'b1;
                                if (!lz_valid_next) begin
                                    done_next  = 1'b1;
                                    phase_next = PH_IDLE;
                                end else begin
                                    path_next  = branch_path;
                                    phase_next = PH_RESET;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            path_reg      <= '0;
            found_reg     <= '0;
            slot_reg      <= '0;
            lz_valid_reg  <= 1'b0;
            lz_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                phase_reg    <= phase_next;
                path_reg     <= path_next;
                found_reg    <= found_next;
                slot_reg     <= slot_next;
                lz_valid_reg <= lz_valid_next;
                lz_idx_reg   <= lz_idx_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            wbit_reg  <= wbit_next;
            cmd_reg   <= cmd_next;
            rom_reg   <= rom_next;
            idv_reg   <= idv_next;
            done_reg  <= done_next;
            nodev_reg <= nodev_next;
            mism_reg  <= mism_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign write_bit       = wbit_reg;
    assign command_code    = cmd_reg;
    assign rom_id          = rom_reg;
    assign id_valid        = idv_reg;
    assign search_done     = done_reg;
    assign no_device       = nodev_reg;
    assign family_mismatch = mism_reg;

endmodule

### rtl/core/onewire_rom_search_core.sv
// ROM search decision engine for a 1-Wire master. A start request loads the
// preload path, a bus-reset request returns the search or alarm command, or
// the no-device status if no presence is seen, and each bit request (id bit,
// complement bit) returns the direction bit to write; the last bit of a pass
// also returns the found id and the search status. Every request gives
// exactly one result. The block takes one request per clock while the result
// channel is not stalled: the search state is updated between the input
// register and the result register, so requests can overlap in flight.
module onewire_rom_search_core #(
    parameter int ID_BITS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] first_bit, [1] complement_bit, zero padded
    input  logic [owrs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [owrs_pkg::KIND_W-1:0]      s_axis_tuser,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] write_bit, [8:1] command_code, [ID_BITS+8:9] rom_id, then id_valid,
    // search_done, no_device, family_mismatch, zero padded
    output logic [((ID_BITS+13+7)/8)*8-1:0]  m_axis_tdata,
    // configuration
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [owrs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [owrs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import owrs_pkg::*;

    localparam int OUT_W       = ID_BITS + 13;
    localparam int M_TDATA_W   = ((OUT_W + 7) / 8) * 8;

    cfg_t               cfg;
    item_t              s_item;
    item_t              item;
    logic               item_valid;
    logic               advance;
    logic               write_bit;
    logic [CMD_W-1:0]   command_code;
    logic [ID_BITS-1:0] rom_id;
    logic               id_valid;
    logic               search_done;
    logic               no_device;
    logic               family_mismatch;

    assign s_item.kind           = s_axis_tuser;
    assign s_item.first_bit      = s_axis_tdata[0];
    assign s_item.complement_bit = s_axis_tdata[1];

    owrs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owrs_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance)
    );

    owrs_engine #(
        .ID_BITS (ID_BITS)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .item_valid      (item_valid),
        .item            (item),
        .advance         (advance),
        .m_valid         (m_axis_tvalid),
        .m_ready         (m_axis_tready),
        .write_bit       (write_bit),
        .command_code    (command_code),
        .rom_id          (rom_id),
        .id_valid        (id_valid),
        .search_done     (search_done),
        .no_device       (no_device),
        .family_mismatch (family_mismatch)
    );

    assign m_axis_tdata = M_TDATA_W'({family_mismatch, no_device, search_done, id_valid,
                                      rom_id, command_code, write_bit});

endmodule
